// ===== hdl/tma_pkg.sv =====
// Shared widths, payload types and window rounding for the triaxial moving average.
package tma_pkg;

  localparam int unsigned SENSOR_W = 2;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MEAN_W   = 24;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned AXES     = 3;
  localparam int unsigned FRAC_W   = 8;

  localparam logic [CFG_W-1:0] WIN_REQ_RESET = 8'd32;

  // One stored three-axis sample
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
  } sample_t;

  // One three-axis mean in 8-fraction-bit fixed point
  typedef struct packed {
    logic signed [MEAN_W-1:0] x;
    logic signed [MEAN_W-1:0] y;
    logic signed [MEAN_W-1:0] z;
  } mean_t;

  // Round a requested window up to 1, 4, 8, 16 or 32; pass larger requests as given
  function automatic logic [8:0] round_window(input logic [CFG_W-1:0] req);
    logic [8:0] w;
    if (req > 8'd32) begin
      w = {1'b0, req};
    end else if (req > 8'd16) begin
      w = 9'd32;
    end else if (req > 8'd8) begin
      w = 9'd16;
    end else if (req > 8'd4) begin
      w = 9'd8;
    end else if (req > 8'd1) begin
      w = 9'd4;
    end else begin
      w = 9'd1;
    end
    return w;
  endfunction

endpackage

// ===== hdl/tma_in_if.sv =====
// Sample request channel: sensor tag and three raw axis readings.
interface tma_in_if import tma_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [SENSOR_W-1:0]        sensor;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;
  logic signed [SAMPLE_W-1:0] sample_z;

  modport source (output valid, sensor, sample_x, sample_y, sample_z, input ready);
  modport sink (input valid, sensor, sample_x, sample_y, sample_z, output ready);
endinterface

// ===== hdl/tma_out_if.sv =====
// Result request channel: three axis means and the averaged sample count.
interface tma_out_if import tma_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] mean_x;
  logic signed [MEAN_W-1:0] mean_y;
  logic signed [MEAN_W-1:0] mean_z;
  logic [COUNT_W-1:0]       stored_count;

  modport source (output valid, mean_x, mean_y, mean_z, stored_count, input ready);
  modport sink (input valid, mean_x, mean_y, mean_z, stored_count, output ready);
endinterface

// ===== hdl/triaxial_moving_average.sv =====
// Per-sensor sliding-window mean of three-axis samples, window store in one RAM.
//
//   channel  direction  handshake       payload
//   in_i     sink       valid/ready     sensor, sample_x, sample_y, sample_z
//   out_o    source     valid/ready     mean_x, mean_y, mean_z, stored_count
//   cfg      sink       cfg_we_i        cfg_wdata_i = window_request
//
// One request at a time. The sample RAM read port walks the stored samples, one stored
// entry a cycle, then the bit-serial divider produces one quotient bit a cycle. A
// request for an unknown sensor goes straight to the output register.
// Reset clears fill counts and oldest pointers; the sample RAM needs no clearing.
// A stalled result sits in the output register while the next request is taken.
module triaxial_moving_average import tma_pkg::*; #(
  parameter int unsigned MAX_WINDOW   = 32,
  parameter int unsigned SENSOR_COUNT = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  tma_in_if.sink           in_i,
  tma_out_if.source        out_o
);

  localparam int unsigned CW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SI    = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int unsigned DEPTH = SENSOR_COUNT * MAX_WINDOW;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = SAMPLE_W + CW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUM  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CFG_W-1:0]    win_req_q;
  logic [CW-1:0]       fill_q   [SENSOR_COUNT];
  logic [PW-1:0]       oldest_q [SENSOR_COUNT];

  logic [AW-1:0]       base_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       issued_q;
  logic [PW-1:0]       rd_ptr_q;
  logic                rd_vld_q;
  logic                bad_q;
  logic signed [SW-1:0] acc_q [AXES];

  logic                out_valid_q;
  mean_t               out_mean_q;
  logic [COUNT_W-1:0]  out_cnt_q;

  logic                in_ready;
  logic                in_acc;
  logic [2:0]          sensor_ext;
  logic                sens_ok;
  logic [SI-1:0]       sens_idx;
  logic [CW-1:0]       fill_cur;
  logic [PW-1:0]       oldest_cur;
  logic [8:0]          win_round;
  logic [CW-1:0]       win_eff;
  logic [CW:0]         slot_sum;
  logic [PW-1:0]       slot;
  logic [CW:0]         cnt1;
  logic [CW:0]         osum;
  logic [CW-1:0]       count_new;
  logic [PW-1:0]       oldest_new;
  logic [AW-1:0]       base;
  logic                wr_en;
  logic [AW-1:0]       waddr;
  sample_t             wdata;

  logic                rd_en;
  logic [AW-1:0]       raddr;
  logic [PW-1:0]       rd_ptr_next;
  logic [$bits(sample_t)-1:0] ram_rdata;
  sample_t             rd_s;
  logic signed [SAMPLE_W-1:0] rd_ax [AXES];

  logic                div_start;
  logic                div_done;
  mean_t               div_quot;
  logic                out_load;

  // Effective window from the request, saturated at the store depth
  assign win_round = round_window(win_req_q);
  assign win_eff   = (win_round > 9'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(win_round);

  // Decode the incoming sensor and look up its window state
  assign in_ready   = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_ready;
  assign sensor_ext = {1'b0, in_i.sensor};
  assign sens_ok    = (32'(sensor_ext) < SENSOR_COUNT);
  assign sens_idx   = sensor_ext[SI-1:0];
  assign fill_cur   = fill_q[sens_idx];
  assign oldest_cur = oldest_q[sens_idx];

  // Append slot and the new oldest pointer and count after dropping
  always_comb begin
    slot_sum = (CW+1)'(oldest_cur) + (CW+1)'(fill_cur);
    slot     = (slot_sum >= (CW+1)'(MAX_WINDOW)) ? PW'(slot_sum - (CW+1)'(MAX_WINDOW))
                                                 : PW'(slot_sum);
    cnt1     = (CW+1)'(fill_cur) + 1'b1;
    osum     = (CW+1)'(oldest_cur) + (cnt1 - (CW+1)'(win_eff));
    if (cnt1 > (CW+1)'(win_eff)) begin
      count_new  = win_eff;
      oldest_new = (osum >= (CW+1)'(MAX_WINDOW)) ? PW'(osum - (CW+1)'(MAX_WINDOW))
                                                 : PW'(osum);
    end else begin
      count_new  = CW'(cnt1);
      oldest_new = oldest_cur;
    end
  end

  // Write the new sample into its sensor's region
  assign base     = AW'(32'(sens_idx) * MAX_WINDOW);
  assign wr_en    = in_acc && sens_ok;
  assign waddr    = base + AW'(slot);
  assign wdata.x  = in_i.sample_x;
  assign wdata.y  = in_i.sample_y;
  assign wdata.z  = in_i.sample_z;

  // Walk the stored entries from the oldest, one read a cycle
  assign rd_en       = (state_q == S_SUM) && (issued_q != count_q);
  assign raddr       = base_q + AW'(rd_ptr_q);
  assign rd_ptr_next = (rd_ptr_q == PW'(MAX_WINDOW - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign rd_s        = sample_t'(ram_rdata);
  assign rd_ax[0]    = rd_s.x;
  assign rd_ax[1]    = rd_s.y;
  assign rd_ax[2]    = rd_s.z;

  tma_ram #(
    .WIDTH ($bits(sample_t)),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  tma_div #(
    .NUM_W (SW),
    .DEN_W (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q),
    .den_i   (count_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequence: accept, sum, divide, hand off to the output register; an unknown sensor skips sum and divide
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign div_start = (state_q == S_SUM) && (issued_q == count_q) && !rd_vld_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = sens_ok ? S_SUM : S_DONE;
        end
      end
      S_SUM: begin
        if (div_start) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, configuration and per-sensor window bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_req_q   <= WIN_REQ_RESET;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        fill_q[s]   <= '0;
        oldest_q[s] <= '0;
      end
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (cfg_we_i) begin
        win_req_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        fill_q[sens_idx]   <= count_new;
        oldest_q[sens_idx] <= oldest_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request context, read walk and accumulators
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      base_q   <= base;
      count_q  <= sens_ok ? count_new : '0;
      rd_ptr_q <= oldest_new;
      issued_q <= '0;
      bad_q    <= !sens_ok;
      for (int a = 0; a < AXES; a++) begin
        acc_q[a] <= '0;
      end
    end else begin
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_next;
        issued_q <= issued_q + 1'b1;
      end
      if (rd_vld_q) begin
        for (int a = 0; a < AXES; a++) begin
          acc_q[a] <= acc_q[a] + {{(SW - SAMPLE_W){rd_ax[a][SAMPLE_W-1]}}, rd_ax[a]};
        end
      end
    end
  end

  // Output register: zeros and a zero count mark an unknown sensor
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mean_q <= bad_q ? '0 : div_quot;
      out_cnt_q  <= COUNT_W'(count_q);
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.mean_x       = out_mean_q.x;
  assign out_o.mean_y       = out_mean_q.y;
  assign out_o.mean_z       = out_mean_q.z;
  assign out_o.stored_count = out_cnt_q;

endmodule

// ===== hdl/tma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tma_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 96,
  parameter int unsigned AW    = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/tma_div.sv =====
// Bit-serial signed divider, three lanes: (sum * 256) / count, truncated toward zero.
module tma_div import tma_pkg::*; #(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i [AXES],
  input  logic [DEN_W-1:0]        den_i,
  output logic                    done_o,
  output mean_t                   quot_o
);

  localparam int unsigned DW   = NUM_W + FRAC_W;
  localparam int unsigned CNTW = $clog2(DW + 1);

  logic [DW-1:0]    mag_q  [AXES];
  logic [DEN_W-1:0] rem_q  [AXES];
  logic             neg_q  [AXES];
  logic [DEN_W-1:0] den_q;
  logic [CNTW-1:0]  step_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   trial  [AXES];
  logic             fits   [AXES];
  logic [DW-1:0]    scaled [AXES];
  logic [DW-1:0]    q_full [AXES];

  // Form the scaled numerator, one restoring step per lane, and the signed quotient
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      scaled[a] = {num_i[a], {FRAC_W{1'b0}}};
      trial[a]  = {rem_q[a], mag_q[a][DW-1]};
      fits[a]   = (trial[a] >= {1'b0, den_q});
      q_full[a] = neg_q[a] ? (~mag_q[a] + 1'b1) : mag_q[a];
    end
  end

  // Step control: load on start, run DW steps, flag done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == CNTW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  // Lane datapath: take magnitudes on start, shift quotient bits in while busy
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      for (int a = 0; a < AXES; a++) begin
        neg_q[a] <= num_i[a][NUM_W-1];
        mag_q[a] <= num_i[a][NUM_W-1] ? (~scaled[a] + 1'b1) : scaled[a];
        rem_q[a] <= '0;
      end
    end else if (busy_q) begin
      for (int a = 0; a < AXES; a++) begin
        rem_q[a] <= fits[a] ? DEN_W'(trial[a] - {1'b0, den_q}) : DEN_W'(trial[a]);
        mag_q[a] <= {mag_q[a][DW-2:0], fits[a]};
      end
    end
  end

  assign done_o   = done_q;
  assign quot_o.x = q_full[0][MEAN_W-1:0];
  assign quot_o.y = q_full[1][MEAN_W-1:0];
  assign quot_o.z = q_full[2][MEAN_W-1:0];

endmodule

// ===== hdl/tma_checker.sv =====
// Port-level checks for the triaxial moving average, bound to the top level.
module tma_checker import tma_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 32
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic signed [MEAN_W-1:0] mean_x_i,
  input logic signed [MEAN_W-1:0] mean_y_i,
  input logic signed [MEAN_W-1:0] mean_z_i,
  input logic [COUNT_W-1:0]       stored_count_i
);

  localparam bit CountFits = (MAX_WINDOW < 64);

  // One request in flight: an accepted request closes the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a request is in flight");

  // Held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mean_x_i) &&
      $stable(mean_y_i) && $stable(mean_z_i) && $stable(stored_count_i))
    else $error("stalled result changed");

  // A zero count flags an unknown sensor and carries zero means
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CountFits && out_valid_i && stored_count_i == '0 |->
      mean_x_i == '0 && mean_y_i == '0 && mean_z_i == '0)
    else $error("unknown sensor result with nonzero mean");

  // A single-sample mean has no fraction bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CountFits && out_valid_i && stored_count_i == COUNT_W'(1) |->
      mean_x_i[FRAC_W-1:0] == '0 && mean_y_i[FRAC_W-1:0] == '0 &&
      mean_z_i[FRAC_W-1:0] == '0)
    else $error("single-sample mean has a fraction");

endmodule

bind triaxial_moving_average tma_checker #(
  .MAX_WINDOW (MAX_WINDOW)
) u_tma_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .mean_x_i       (out_o.mean_x),
  .mean_y_i       (out_o.mean_y),
  .mean_z_i       (out_o.mean_z),
  .stored_count_i (out_o.stored_count)
);
